// ===== sv/alternating_bit_sender_defines.svh =====
// Assertion macros for the alternating-bit sender.
// Used by the top level only; no other dependencies.
`ifndef ALTERNATING_BIT_SENDER_DEFINES_SVH
`define ALTERNATING_BIT_SENDER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ABS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("alternating_bit_sender: assertion failed");
// next-cycle implication
`define ABS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("alternating_bit_sender: assertion failed");
`else
`define ABS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ABS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/abs_pkg.sv =====
// Shared types and constants of the alternating-bit sender.
// No dependencies; imported by abs_lane, abs_merge and the top level.
package abs_pkg;

    localparam int MAX_BYTES         = 20;
    localparam int PAYLOAD_BYTES_DEF = 20;
    localparam int BYTE_W            = 8;
    localparam int PROD_W            = 13;  // 19 * -128 fits
    localparam int SUM_W             = 16;
    localparam int GROUP_LANES       = 5;
    localparam int WORD_W            = 32;
    localparam int TIMEOUT_W         = 16;
    localparam int BYTES_W           = MAX_BYTES * BYTE_W;
    localparam int IN_DATA_W         = BYTES_W + 2 * WORD_W;
    localparam int IN_USER_W         = 2;
    localparam int OUT_DATA_W        = 184;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

    localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_K = 8'h4B;

    // result bit positions inside m_axis_tdata
    localparam int OUT_SEND_VALID = 0;
    localparam int OUT_REFUSED    = 180;
    localparam int OUT_ACK_ACC    = 181;
    localparam int OUT_TSTOP      = 179;

    typedef enum logic [1:0] {
        ACT_MSG = 2'd0,
        ACT_PKT = 2'd1,
        ACT_TMR = 2'd2
    } action_t;

    typedef struct packed {
        logic adv;   // lane register load
        logic keep;  // byte survives mask and zero-cut
    } lane_ctrl_t;

endpackage

// ===== sv/abs_lane.sv =====
// One checksum lane: masks its payload byte and forms index * signed byte.
// Depends on abs_pkg.
module abs_lane import abs_pkg::*; #(
    parameter int LANE_IDX = 0
) (
    input  logic                     aclk,
    input  lane_ctrl_t               ctrl,
    input  logic [BYTE_W-1:0]        data_in,
    output logic [BYTE_W-1:0]        data_reg,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic [BYTE_W-1:0]        lane_data;
    logic signed [PROD_W-1:0] data_ext;
    logic signed [PROD_W-1:0] weight;
    logic signed [PROD_W-1:0] prod_next;

    assign lane_data = ctrl.keep ? data_in : '0;
    assign data_ext  = PROD_W'(signed'(lane_data));
    assign weight    = PROD_W'(LANE_IDX);
    assign prod_next = data_ext * weight;

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            data_reg <= lane_data;
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== sv/abs_merge.sv =====
// Merge stage: registered group sums of the lane products, then the total.
// Depends on abs_pkg.
module abs_merge import abs_pkg::*; #(
    parameter int NUM_LANES = PAYLOAD_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     adv,
    input  logic signed [PROD_W-1:0] prod [NUM_LANES],
    output logic signed [SUM_W-1:0]  total
);

    localparam int NUM_GROUPS = (NUM_LANES + GROUP_LANES - 1) / GROUP_LANES;
    localparam int PAD_LANES  = NUM_GROUPS * GROUP_LANES;

    logic signed [PROD_W-1:0] prod_pad   [PAD_LANES];
    logic signed [SUM_W-1:0]  group_next [NUM_GROUPS];
    logic signed [SUM_W-1:0]  group_reg  [NUM_GROUPS];

    for (genvar i = 0; i < PAD_LANES; i++) begin : g_pad
        if (i < NUM_LANES) begin : g_real
            assign prod_pad[i] = prod[i];
        end else begin : g_zero
            assign prod_pad[i] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_LANES; k++) begin
                group_next[g] = group_next[g] + SUM_W'(prod_pad[g * GROUP_LANES + k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            total = total + group_reg[g];
        end
    end

endmodule

// ===== sv/alternating_bit_sender.sv =====
// Alternating-bit sender: lane array, merge stage, decision stage, state.
// Depends on abs_pkg, abs_lane, abs_merge and alternating_bit_sender_defines.svh.
//
// Usage
//   s_axis carries one event per transaction: tuser is the action (0 message from
//   the upper layer, 1 packet from the network, 2 timer expiry, 3 ignored), tdata
//   the 20 payload bytes, the incoming ack number and the incoming checksum.
//   m_axis returns exactly one result per event: send flag, sequence bit, sent
//   bytes, checksum and the timer / refusal / ack flags.
//   cfg_* writes retransmit_timeout; cfg_ready is always high. Write it only
//   while no event is in flight.
// Timing
//   Three register stages: byte lanes, group sums, result register. One event
//   per cycle sustained while m_axis_tready is high. The sender state is read
//   and updated only in the decision stage, so events that follow back to back
//   see the state their predecessors left.
// Reset
//   aresetn low for one clock empties the pipeline and restores held_seq = 1,
//   held bytes and checksum zero, no ack seen, timeout 500.
// Stall
//   While m_axis_tready is low the result holds; earlier stages keep filling
//   until every stage is full, then s_axis_tready drops.
module alternating_bit_sender import abs_pkg::*; #(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // event channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: payload_low[63:0], payload_mid[127:64], payload_high[159:128],
    //        incoming_ack[191:160], incoming_sum[223:192]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: send_valid[0], send_seq[1], send_bytes_low[65:2],
    //        send_bytes_mid[129:66], send_bytes_high[161:130], send_sum[177:162],
    //        timer_start[178], timer_stop[179], message_refused[180],
    //        ack_accepted[181], zero pad[183:182]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // retransmit_timeout write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TIMEOUT_W-1:0]  cfg_data
);

`include "alternating_bit_sender_defines.svh"

    // ---------------- handshake / stage enables ----------------
    logic adv1, adv2, adv3;

    logic                  s1_valid_reg, s2_valid_reg, m_valid_reg;
    action_t               s1_action_reg, s2_action_reg;
    logic [WORD_W-1:0]     s1_ack_reg, s2_ack_reg;
    logic signed [WORD_W-1:0] s1_sum_reg, s2_sum_reg;
    logic [BYTE_W-1:0]     s2_bytes_reg [MAX_BYTES];
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] result_next;

    // the result register frees a slot when empty or taken; each earlier
    // stage moves when its successor has room
    assign adv3          = !m_valid_reg || m_axis_tready;
    assign adv2          = !s2_valid_reg || adv3;
    assign adv1          = !s1_valid_reg || adv2;
    assign s_axis_tready = adv1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

    // ---------------- lane control: mask and zero-cut ----------------
    action_t           in_action;
    logic [BYTE_W-1:0] in_bytes   [MAX_BYTES];
    logic [MAX_BYTES-1:0] zero_flag;
    logic [MAX_BYTES-1:0] cut_before;

    assign in_action = action_t'(s_axis_tuser);

    always_comb begin
        for (int i = 0; i < MAX_BYTES; i++) begin
            in_bytes[i]  = s_axis_tdata[i * BYTE_W +: BYTE_W];
            zero_flag[i] = (in_bytes[i] == '0);
        end
        // a message is cut after its first zero byte
        for (int i = 0; i < MAX_BYTES; i++) begin
            cut_before[i] = 1'b0;
            for (int j = 0; j < MAX_BYTES; j++) begin
                if (j < i) begin
                    cut_before[i] = cut_before[i] | zero_flag[j];
                end
            end
        end
    end

    // ---------------- lanes ----------------
    logic [BYTE_W-1:0]        lane_bytes [PAYLOAD_BYTES];
    logic signed [PROD_W-1:0] lane_prod  [PAYLOAD_BYTES];
    logic [BYTE_W-1:0]        s1_bytes   [MAX_BYTES];

    for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_lane
        lane_ctrl_t ctrl;
        assign ctrl.adv  = adv1;
        assign ctrl.keep = (in_action != ACT_MSG) || !cut_before[i];

        abs_lane #(.LANE_IDX(i)) u_lane (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .data_in  (in_bytes[i]),
            .data_reg (lane_bytes[i]),
            .prod_reg (lane_prod[i])
        );
    end

    // bytes past the payload length read as zero
    for (genvar i = 0; i < MAX_BYTES; i++) begin : g_s1_bytes
        if (i < PAYLOAD_BYTES) begin : g_real
            assign s1_bytes[i] = lane_bytes[i];
        end else begin : g_zero
            assign s1_bytes[i] = '0;
        end
    end

    // ---------------- merge (group sums registered with stage 2) ----------------
    logic signed [SUM_W-1:0] s2_total;

    abs_merge #(.NUM_LANES(PAYLOAD_BYTES)) u_merge (
        .aclk  (aclk),
        .adv   (adv2),
        .prod  (lane_prod),
        .total (s2_total)
    );

    // ---------------- pipeline registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (adv1) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (adv2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_action_reg <= in_action;
            s1_ack_reg    <= s_axis_tdata[BYTES_W +: WORD_W];
            s1_sum_reg    <= s_axis_tdata[BYTES_W + WORD_W +: WORD_W];
        end
        if (adv2) begin
            s2_action_reg <= s1_action_reg;
            s2_ack_reg    <= s1_ack_reg;
            s2_sum_reg    <= s1_sum_reg;
            for (int i = 0; i < MAX_BYTES; i++) begin
                s2_bytes_reg[i] <= s1_bytes[i];
            end
        end
        if (adv3 && s2_valid_reg) begin
            m_data_reg <= result_next;
        end
    end

    // ---------------- sender state ----------------
    logic                 held_seq_reg,  held_seq_next;
    logic [BYTE_W-1:0]    held_bytes_reg [MAX_BYTES];
    logic [BYTE_W-1:0]    held_bytes_next [MAX_BYTES];
    logic [SUM_W-1:0]     held_sum_reg,  held_sum_next;
    logic                 ack_seen_reg,  ack_seen_next;
    logic                 acked_seq_reg, acked_seq_next;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic commit;
    assign commit = adv3 && s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_seq_reg  <= 1'b1;
            held_sum_reg  <= '0;
            ack_seen_reg  <= 1'b0;
            acked_seq_reg <= 1'b0;
            for (int i = 0; i < MAX_BYTES; i++) begin
                held_bytes_reg[i] <= '0;
            end
        end else if (commit) begin
            held_seq_reg  <= held_seq_next;
            held_sum_reg  <= held_sum_next;
            ack_seen_reg  <= ack_seen_next;
            acked_seq_reg <= acked_seq_next;
            for (int i = 0; i < MAX_BYTES; i++) begin
                held_bytes_reg[i] <= held_bytes_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    // ---------------- decision ----------------
    logic                 new_seq;
    logic                 pkt_ok;
    logic                 emit;
    logic                 timer_start, timer_stop, refused, ack_acc;
    logic [BYTES_W-1:0]   send_bytes;

    always_comb begin
        held_seq_next  = held_seq_reg;
        held_sum_next  = held_sum_reg;
        ack_seen_next  = ack_seen_reg;
        acked_seq_next = acked_seq_reg;
        for (int i = 0; i < MAX_BYTES; i++) begin
            held_bytes_next[i] = held_bytes_reg[i];
        end
        emit        = 1'b0;
        timer_stop  = 1'b0;
        refused     = 1'b0;
        ack_acc     = 1'b0;
        new_seq     = !held_seq_reg;
        pkt_ok      = (WORD_W'(s2_total) == s2_sum_reg)
                      && (s2_bytes_reg[0] == CHAR_A)
                      && (s2_bytes_reg[1] == CHAR_C)
                      && (s2_bytes_reg[2] == CHAR_K)
                      && (s2_ack_reg == WORD_W'(held_seq_reg));

        case (s2_action_reg)
            ACT_MSG: begin
                if (ack_seen_reg && (acked_seq_reg == new_seq)) begin
                    refused = 1'b1;
                end else begin
                    held_seq_next = new_seq;
                    held_sum_next = s2_total;
                    for (int i = 0; i < MAX_BYTES; i++) begin
                        held_bytes_next[i] = s2_bytes_reg[i];
                    end
                    emit = 1'b1;
                end
            end
            ACT_PKT: begin
                if (pkt_ok) begin
                    ack_seen_next  = 1'b1;
                    acked_seq_next = s2_ack_reg[0];
                    timer_stop     = 1'b1;
                    ack_acc        = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            ACT_TMR: begin
                emit = !ack_seen_reg || (acked_seq_reg != held_seq_reg);
            end
            default: begin
                // unused action: all-zero result
            end
        endcase

        timer_start = emit;
        for (int i = 0; i < MAX_BYTES; i++) begin
            send_bytes[i * BYTE_W +: BYTE_W] = emit ? held_bytes_next[i] : '0;
        end
        result_next = {2'b00, ack_acc, refused, timer_stop, timer_start,
                       (emit ? held_sum_next : SUM_W'(0)), send_bytes,
                       (emit & held_seq_next), emit};
    end

    // ---------------- checks ----------------
    `ABS_ASSERT_NEXT(a_state_holds_on_stall, aclk, aresetn,
        aresetn && m_valid_reg && !m_axis_tready,
        $stable(held_seq_reg) && $stable(ack_seen_reg) && $stable(acked_seq_reg))
    `ABS_ASSERT_IMPL(a_refuse_needs_ack, aclk, aresetn,
        m_valid_reg && m_data_reg[OUT_REFUSED], ack_seen_reg)
    `ABS_ASSERT_IMPL(a_ack_stops_timer, aclk, aresetn,
        m_valid_reg && m_data_reg[OUT_ACK_ACC],
        m_data_reg[OUT_TSTOP] && !m_data_reg[OUT_SEND_VALID] && ack_seen_reg)
    `ABS_ASSERT_NEXT(a_cfg_write_lands, aclk, aresetn,
        aresetn && cfg_valid && cfg_ready, timeout_reg == $past(cfg_data))

endmodule
